### hdl/bpa_pkg.sv
// Bitmap page allocator package: sizes, status codes, payload structs, sequencer states.
// No dependencies; imported by every file of the allocator.
`timescale 1ns / 1ps

package bpa_pkg;

  localparam int unsigned PAGE_COUNT = 4096;
  localparam int unsigned PAGE_SHIFT = 12;
  localparam int unsigned MAP_WORDS  = (PAGE_COUNT + 7) / 8;
  localparam int unsigned WORD_AW    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned CNT_W      = $clog2(MAP_WORDS + 1);
  localparam int unsigned PG_W       = WORD_AW + 3;

  localparam logic [63:0] BASE_RESET = 64'h0000_0000_0010_0000;

  // Bits of the last map word past PAGE_COUNT count as used pages.
  localparam logic [7:0] LAST_SPARE =
    ((PAGE_COUNT % 8) == 0) ? 8'h00 : 8'(8'hFF << (PAGE_COUNT % 8));

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic [1:0] ST_ALLOCATED    = 2'd0;
  localparam logic [1:0] ST_NO_FREE      = 2'd1;
  localparam logic [1:0] ST_FREED        = 2'd2;
  localparam logic [1:0] ST_OUT_OF_RANGE = 2'd3;

  typedef struct packed {
    logic        kind;
    logic [63:0] address;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] page_address;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_ALLOC_ADD,
    S_FREE_SUB,
    S_FREE_RD,
    S_FREE_WR,
    S_DONE
  } state_e;

endpackage

### hdl/bpa_engine.sv
// Allocator engine: used-page map memory, scan/free sequencer and shared 64-bit adder.
// Depends on bpa_pkg.
`timescale 1ns / 1ps

module bpa_engine (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  bpa_pkg::req_t req_i,
  input  logic [63:0]   base_i,
  output logic          busy_o,
  output logic          res_valid_o,
  input  logic          res_ready_i,
  output bpa_pkg::rsp_t rsp_o
);
  import bpa_pkg::*;

  state_e               state_q, state_d;
  logic [CNT_W-1:0]     scan_q, scan_d;
  logic [CNT_W-1:0]     hwm_q, hwm_d;
  logic [WORD_AW-1:0]   chk_idx_q, chk_idx_d;
  logic                 chk_vld_q, chk_vld_d;
  logic [63:0]          addr_q, addr_d;
  logic [PG_W-1:0]      page_q, page_d;
  logic                 inrange_q, inrange_d;
  logic [1:0]           status_q, status_d;
  logic [63:0]          res_addr_q, res_addr_d;

  logic [7:0]           map_mem [MAP_WORDS];
  logic [7:0]           rdata_q;
  logic                 mem_we, mem_re;
  logic [WORD_AW-1:0]   mem_waddr, mem_raddr;
  logic [7:0]           mem_wdata;

  logic [63:0]          opa, opb, sum;
  logic                 sub;
  logic [7:0]           word_eff;
  logic [2:0]           free_bit;
  logic [WORD_AW-1:0]   free_word;

  function automatic logic [2:0] lowest_zero(input logic [7:0] w);
    logic [2:0] idx;
    idx = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (!w[i]) idx = 3'(i);
    end
    return idx;
  endfunction

  // Shared adder: address offset on free, page address on allocate.
  assign sum = opa + (sub ? ~opb : opb) + 64'(sub);

  // Words at or above the high-water mark have never been written: they read as free.
  always_comb begin
    word_eff = (CNT_W'(chk_idx_q) < hwm_q) ? rdata_q : 8'h00;
    if (chk_idx_q == WORD_AW'(MAP_WORDS - 1)) word_eff = word_eff | LAST_SPARE;
  end

  assign free_word = page_q[PG_W-1:3];
  assign free_bit  = page_q[2:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) map_mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= map_mem[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      scan_q    <= '0;
      hwm_q     <= '0;
      chk_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      scan_q    <= scan_d;
      hwm_q     <= hwm_d;
      chk_vld_q <= chk_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chk_idx_q  <= chk_idx_d;
    addr_q     <= addr_d;
    page_q     <= page_d;
    inrange_q  <= inrange_d;
    status_q   <= status_d;
    res_addr_q <= res_addr_d;
  end

  always_comb begin
    state_d    = state_q;
    scan_d     = scan_q;
    hwm_d      = hwm_q;
    chk_idx_d  = chk_idx_q;
    chk_vld_d  = 1'b0;
    addr_d     = addr_q;
    page_d     = page_q;
    inrange_d  = inrange_q;
    status_d   = status_q;
    res_addr_d = res_addr_q;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_waddr  = chk_idx_q;
    mem_raddr  = scan_q[WORD_AW-1:0];
    mem_wdata  = word_eff;
    opa        = addr_q;
    opb        = base_i;
    sub        = 1'b1;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          addr_d = req_i.address;
          scan_d = '0;
          state_d = (req_i.kind == KIND_FREE) ? S_FREE_SUB : S_SCAN;
        end
      end
      S_SCAN: begin
        // Read word scan_q while checking the word read last cycle.
        chk_idx_d = scan_q[WORD_AW-1:0];
        if (scan_q < CNT_W'(MAP_WORDS)) begin
          mem_re    = 1'b1;
          scan_d    = scan_q + CNT_W'(1);
          chk_vld_d = 1'b1;
        end
        if (chk_vld_q) begin
          if (word_eff != 8'hFF) begin
            mem_we    = 1'b1;
            mem_wdata = word_eff | (8'h01 << lowest_zero(word_eff));
            if (CNT_W'(chk_idx_q) == hwm_q) hwm_d = hwm_q + CNT_W'(1);
            page_d    = {chk_idx_q, lowest_zero(word_eff)};
            chk_vld_d = 1'b0;
            state_d   = S_ALLOC_ADD;
          end else if (chk_idx_q == WORD_AW'(MAP_WORDS - 1)) begin
            status_d   = ST_NO_FREE;
            res_addr_d = '0;
            chk_vld_d  = 1'b0;
            state_d    = S_DONE;
          end
        end
      end
      S_ALLOC_ADD: begin
        opa        = 64'(page_q) << PAGE_SHIFT;
        sub        = 1'b0;
        res_addr_d = sum;
        status_d   = ST_ALLOCATED;
        state_d    = S_DONE;
      end
      S_FREE_SUB: begin
        inrange_d = sum[63:PAGE_SHIFT] < (64 - PAGE_SHIFT)'(PAGE_COUNT);
        page_d    = sum[PAGE_SHIFT +: PG_W];
        state_d   = S_FREE_RD;
      end
      S_FREE_RD: begin
        if (inrange_q) begin
          mem_re    = 1'b1;
          mem_raddr = free_word;
          state_d   = S_FREE_WR;
        end else begin
          status_d   = ST_OUT_OF_RANGE;
          res_addr_d = '0;
          state_d    = S_DONE;
        end
      end
      S_FREE_WR: begin
        if (CNT_W'(free_word) < hwm_q) begin
          mem_we    = 1'b1;
          mem_waddr = free_word;
          mem_wdata = rdata_q & ~(8'h01 << free_bit);
        end
        status_d   = ST_FREED;
        res_addr_d = '0;
        state_d    = S_DONE;
      end
      S_DONE: begin
        if (res_ready_i) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o             = (state_q != S_IDLE);
  assign res_valid_o        = (state_q == S_DONE);
  assign rsp_o.status       = status_q;
  assign rsp_o.page_address = res_addr_q;

endmodule

### hdl/bitmap_page_allocator.sv
// Bitmap page allocator top level: base address register, request handshake, result register.
// Depends on bpa_pkg and bpa_engine.
`timescale 1ns / 1ps
//
//  channel   direction  signals                          payload
//  request   in         in_valid_i / in_ready_o          bpa_pkg::req_t  {kind, address}
//  result    out        out_valid_o / out_ready_i        bpa_pkg::rsp_t  {status, page_address}
//  config    in         cfg_we_i                         cfg_wdata_i     base address
//
//  Allocate: the map memory is scanned from word 0 until a word with a free page is found,
//  one word per cycle; the page address is then added to the base and registered for hand-over.
//  Free: subtract, read, write, hand-over; an out-of-range free skips the read and the write.
//  One transaction in work at a time.
//  Reset leaves every page free at once; a high-water mark stands in for clearing the map.
//  A stalled result waits in the output register; a new request may be taken meanwhile.

module bitmap_page_allocator (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  bpa_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output bpa_pkg::rsp_t out_data_o,
  input  logic          cfg_we_i,
  input  logic [63:0]   cfg_wdata_i
);
  import bpa_pkg::*;

  logic [63:0] base_q;
  logic        out_valid_q;
  rsp_t        out_data_q;
  logic        busy, res_valid, res_ready;
  rsp_t        rsp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= BASE_RESET;
    end else if (cfg_we_i) begin
      base_q <= cfg_wdata_i;
    end
  end

  bpa_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_valid_i && in_ready_o),
    .req_i       (in_data_i),
    .base_i      (base_q),
    .busy_o      (busy),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .rsp_o       (rsp)
  );

  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) out_data_q <= rsp;
  end

  assign in_ready_o  = !busy;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

### hdl/bpa_checker.sv
// Port-level checks for the bitmap page allocator, bound to the top level.
// Depends on bpa_pkg and bitmap_page_allocator.
`timescale 1ns / 1ps

module bpa_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input bpa_pkg::rsp_t out_data_o
);
  import bpa_pkg::*;

  // Only an allocation carries an address.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status != ST_ALLOCATED) |-> (out_data_o.page_address == 64'd0))
    else $error("non-allocation result with non-zero address");

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("result dropped or changed while stalled");

  // An accepted request leaves the block busy in the cycle after.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request taken while previous one still in work");

  // A result only appears at the end of work on a request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result without a request in work");

endmodule

bind bitmap_page_allocator bpa_checker u_bpa_checker (.*);

### test/tb_bitmap_page_allocator.sv
// Self-checking testbench for bitmap_page_allocator: directed table, then random traffic.
// Depends on bpa_pkg and the allocator RTL; results are checked against an in-bench predictor.
`timescale 1ns / 1ps

module tb_bitmap_page_allocator;
  import bpa_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 20_000_000;
  localparam int unsigned HOLD_CYCLES  = 3000;
  localparam int unsigned SETTLE_CYCLS = 600;
  localparam int unsigned PAGE_BYTES   = 1 << PAGE_SHIFT;

  typedef struct packed {
    logic typed;
    req_t req;
    rsp_t rsp;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  req_t        in_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  rsp_t        out_data_o;
  logic        cfg_we_i;
  logic [63:0] cfg_wdata_i;

  // predictor state
  bit          page_used [PAGE_COUNT];
  int unsigned used_cnt;
  int unsigned free_hint;
  logic [63:0] base_q;

  rsp_t        pending_rsp[$];
  rsp_t        want_rsp;
  int unsigned err_cnt = 0;
  logic        hold_req;

  dir_row_t dir_rows [0:13] = '{
    '{1'b1, '{KIND_ALLOC, 64'h0},                   '{ST_ALLOCATED, 64'h0000_0000_0010_0000}},
    '{1'b1, '{KIND_ALLOC, 64'hFFFF_FFFF_FFFF_FFFF}, '{ST_ALLOCATED, 64'h0000_0000_0010_1000}},
    '{1'b1, '{KIND_FREE,  64'h0000_0000_0010_0000}, '{ST_FREED, 64'h0}},
    '{1'b1, '{KIND_ALLOC, 64'h0},                   '{ST_ALLOCATED, 64'h0000_0000_0010_0000}},
    '{1'b1, '{KIND_FREE,  64'h0000_0000_0010_0FFF}, '{ST_FREED, 64'h0}},
    '{1'b1, '{KIND_FREE,  64'h0000_0000_0010_0000}, '{ST_FREED, 64'h0}},
    '{1'b1, '{KIND_FREE,  64'h0},                   '{ST_OUT_OF_RANGE, 64'h0}},
    '{1'b1, '{KIND_FREE,  64'hFFFF_FFFF_FFFF_FFFF}, '{ST_OUT_OF_RANGE, 64'h0}},
    '{1'b1, '{KIND_FREE,  64'h0000_0000_0110_0000}, '{ST_OUT_OF_RANGE, 64'h0}},
    '{1'b1, '{KIND_FREE,  64'h0000_0000_010F_FFFF}, '{ST_FREED, 64'h0}},
    '{1'b1, '{KIND_FREE,  64'h0000_0000_000F_FFFF}, '{ST_OUT_OF_RANGE, 64'h0}},
    '{1'b0, '{KIND_ALLOC, 64'h0},                   '0},
    '{1'b0, '{KIND_ALLOC, 64'h0},                   '0},
    '{1'b0, '{KIND_FREE,  64'h0000_0000_0010_1800}, '0}
  };

  bitmap_page_allocator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic rsp_t apply_request(req_t r);
    rsp_t        res;
    logic [63:0] pg;
    int unsigned p;
    res = '{ST_NO_FREE, 64'h0};
    if (r.kind == KIND_ALLOC) begin
      for (p = free_hint; p < PAGE_COUNT; p++) begin
        if (!page_used[p]) begin
          page_used[p] = 1'b1;
          used_cnt++;
          free_hint = p + 1;
          res = '{ST_ALLOCATED, base_q + (64'(p) << PAGE_SHIFT)};
          break;
        end
      end
      if (res.status == ST_NO_FREE) free_hint = PAGE_COUNT;
    end else begin
      pg = (r.address - base_q) >> PAGE_SHIFT;
      if (pg >= 64'(PAGE_COUNT)) begin
        res = '{ST_OUT_OF_RANGE, 64'h0};
      end else begin
        if (page_used[pg]) used_cnt--;
        page_used[pg] = 1'b0;
        if (int'(pg) < free_hint) free_hint = int'(pg);
        res = '{ST_FREED, 64'h0};
      end
    end
    return res;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 20);
    return $urandom_range(50, 200);
  endfunction

  function automatic req_t make_req();
    req_t        r;
    int unsigned sel;
    int unsigned lim;
    r.kind    = ($urandom_range(0, 1) == 0) ? KIND_ALLOC : KIND_FREE;
    r.address = {$urandom(), $urandom()};
    if (r.kind == KIND_FREE) begin
      sel = $urandom_range(0, 9);
      if (sel < 7) begin
        lim = used_cnt + 15;
        if (lim > PAGE_COUNT - 1 || $urandom_range(0, 15) == 0) lim = PAGE_COUNT - 1;
        r.address = base_q + (64'($urandom_range(0, lim)) << PAGE_SHIFT)
                  + 64'($urandom_range(0, PAGE_BYTES - 1));
      end else if (sel == 7) begin
        r.address = base_q - 64'($urandom_range(1, 1 << 16));
      end else if (sel == 8) begin
        r.address = base_q + (64'(PAGE_COUNT) << PAGE_SHIFT) + 64'($urandom_range(0, 1 << 20));
      end
    end
    return r;
  endfunction

  task automatic send_req(input req_t r, input logic typed, input rsp_t typed_rsp);
    rsp_t pred;
    in_valid_i <= 1'b1;
    in_data_i  <= r;
    do @(posedge clk_i); while (!in_ready_o);
    pred = apply_request(r);
    pending_rsp.push_back(typed ? typed_rsp : pred);
  endtask

  task automatic idle_gap();
    int unsigned n;
    n = gap_len();
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic send_random(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      send_req(make_req(), 1'b0, '0);
      idle_gap();
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLS) @(posedge clk_i);
  endtask

  task automatic set_base(input logic [63:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    base_q = v;
  endtask

  // result side: random back-pressure, one long hold on request
  initial begin
    bit hold_done;
    hold_done   = 1'b0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done   = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if ($urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat (gap_len()) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_rsp.size() == 0) begin
        $error("unexpected transaction: status %0d page_address %h",
               out_data_o.status, out_data_o.page_address);
        err_cnt++;
      end else begin
        want_rsp = pending_rsp.pop_front();
        if (out_data_o.status !== want_rsp.status) begin
          $error("status: expected %0d, got %0d", want_rsp.status, out_data_o.status);
          err_cnt++;
        end
        if (out_data_o.page_address !== want_rsp.page_address) begin
          $error("page_address: expected %h, got %h",
                 want_rsp.page_address, out_data_o.page_address);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("tb_bitmap_page_allocator: errors");
    $finish;
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    hold_req    = 1'b0;
    used_cnt    = 0;
    free_hint   = 0;
    base_q      = BASE_RESET;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);
      idle_gap();
    end
    drain();

    set_base(64'h0);
    send_random(150);
    drain();

    // all-ones base: allocations wrap; receiver holds off while requests keep coming
    set_base(64'hFFFF_FFFF_FFFF_FFFF);
    hold_req <= 1'b1;
    send_random(150);
    drain();

    set_base(64'h0000_0000_BFEE_0000);
    send_random(150);
    drain();

    set_base(64'hFFFF_FFFF_FFF0_0000);
    send_random(150);
    drain();

    set_base({$urandom(), $urandom()});
    send_random(300);
    drain();

    if (err_cnt == 0)
      $display("tb_bitmap_page_allocator: clean");
    else
      $display("tb_bitmap_page_allocator: errors");
    $finish;
  end

endmodule
